// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, register indexes, reset values and types for the servo
// pulse PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    localparam int MEAS_W     = 16;
    localparam int SET_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int PULSE_W    = 10;
    localparam int PERIOD_W   = 16;
    localparam int CMP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int GAIN_FRAC_BITS = 8;

    // error, derivative and previous error
    localparam int ERR_W   = 18;
    localparam int INTEG_W = 13;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT   = 13'sd3000;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT_N = -13'sd3000;

    // serial multiply-accumulate over the gain bits
    localparam int PP_W    = ERR_W + 2;
    localparam int ACC_W   = PP_W + 1;
    localparam int ACC_X_W = ACC_W + 1;
    localparam int SUM_W   = ACC_W + GAIN_W;
    localparam int PLS_W   = SUM_W + 1;
    localparam int CNT_W   = $clog2(GAIN_W);

    // compare value: period * pulse, then / 1000 as >> 3 and / 125
    localparam int PROD_W    = PERIOD_W + PULSE_W;
    localparam int DIV_SHIFT = 3;
    localparam int DIVD_W    = ((PROD_W - DIV_SHIFT + 1) / 2) * 2;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int REM_W     = 7;
    localparam logic [REM_W:0] DIVISOR = 8'd125;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd7;

    typedef struct packed {
        logic        [SET_W-1:0]    setpoint;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic        [PULSE_W-1:0]  center_pulse;
        logic        [PULSE_W-1:0]  min_pulse;
        logic        [PULSE_W-1:0]  max_pulse;
        logic        [PERIOD_W-1:0] pwm_period;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        setpoint:     16'd75,
        gain_p:       -16'sd236,
        gain_i:       16'sd0,
        gain_d:       16'sd0,
        center_pulse: 10'd70,
        min_pulse:    10'd24,
        max_pulse:    10'd115,
        pwm_period:   16'd20000
    };

endpackage

`default_nettype wire

// ===== rtl/core/pid_servo_pulse_controller.sv =====
// ----------------------------------------------------------------------------
// pid_servo_pulse_controller
// Positional PID with clamped integral, producing a clamped servo pulse in
// per-mille and the matching PWM compare count.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one measured position per
//   beat. Output channel o_out_valid/i_out_ready carries pulse, compare
//   value and the limited flag, one beat per input beat.
//   Configuration is a plain write port (i_cfg_wr_en, i_cfg_addr,
//   i_cfg_wdata); the user writes it while the block is idle, which the block does not enforce.
//   The datapath is bit-serial: shift-add over the gain bits, shift-add
//   over the pulse bits for the compare product, and radix-4 restoring
//   division by 125, plus error, clamp and hand-off states.
//   The input is taken again once a result is parked in the output register,
//   so a stalled receiver holds at most one result plus one in flight.
//   Reset clears the integral and the previous error, returns the
//   configuration to its default values and the state machine to idle;
//   the payload registers are not reset. o_in_ready is high right after
//   reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_servo_pulse_controller
    import psc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [MEAS_W-1:0]     i_measured,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [PULSE_W-1:0]    o_pulse,
    output logic [CMP_W-1:0]      o_compare_value,
    output logic                  o_limited
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ERR   = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // control and state
    t_cfg        r_cfg, n_cfg;
    logic [2:0]  r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [ERR_W-1:0]   r_prev, n_prev;
    logic        r_o_valid, n_o_valid;

    // payload
    logic [MEAS_W-1:0]         r_meas, n_meas;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [ERR_W-1:0]   r_deriv, n_deriv;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [GAIN_W-1:0]         r_lo, n_lo;
    logic [PULSE_W-1:0]        r_pulse, n_pulse;
    logic                      r_limited, n_limited;
    logic [PERIOD_W-1:0]       r_macc, n_macc;
    logic [PULSE_W-1:0]        r_mlo, n_mlo;
    logic [DIVD_W-1:0]         r_div, n_div;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [PULSE_W-1:0]        r_o_pulse, n_o_pulse;
    logic [CMP_W-1:0]          r_o_cmp, n_o_cmp;
    logic                      r_o_limited, n_o_limited;

    // datapath temporaries
    logic signed [ERR_W-1:0]   e_new;
    logic signed [ERR_W-1:0]   integ_raw;
    logic signed [PP_W-1:0]    pp_err, pp_integ, pp_deriv, pp;
    logic signed [ACC_X_W-1:0] acc_x, pp_x, acc_sum;
    logic signed [SUM_W-1:0]   total, drive;
    logic signed [PLS_W-1:0]   pulse_raw, pulse_min, pulse_max;
    logic [PERIOD_W:0]         msum;
    logic [PROD_W-1:0]         product;
    logic [REM_W:0]            t1, t2;
    logic [REM_W-1:0]          r1, r2;
    logic                      q1, q2;

    always_comb begin
        e_new     = $signed({2'b00, r_cfg.setpoint}) - $signed({2'b00, r_meas});
        integ_raw = ERR_W'(r_integ) + e_new;

        pp_err   = r_cfg.gain_p[r_cnt] ? PP_W'(r_err)   : PP_W'(0);
        pp_integ = r_cfg.gain_i[r_cnt] ? PP_W'(r_integ) : PP_W'(0);
        pp_deriv = r_cfg.gain_d[r_cnt] ? PP_W'(r_deriv) : PP_W'(0);
        pp       = pp_err + pp_integ + pp_deriv;
        acc_x    = ACC_X_W'(r_acc);
        pp_x     = ACC_X_W'(pp);
        // the gain's top bit carries negative weight
        acc_sum  = (r_cnt == CNT_W'(GAIN_W - 1)) ? acc_x - pp_x : acc_x + pp_x;

        total     = {r_acc, r_lo};
        drive     = total >>> GAIN_FRAC_BITS;
        pulse_raw = PLS_W'($signed({1'b0, r_cfg.center_pulse})) - PLS_W'(drive);
        pulse_min = PLS_W'($signed({1'b0, r_cfg.min_pulse}));
        pulse_max = PLS_W'($signed({1'b0, r_cfg.max_pulse}));

        msum    = {1'b0, r_macc} + (r_mlo[0] ? {1'b0, r_cfg.pwm_period} : '0);
        // product after this cycle's shift-add step
        product = {msum, r_mlo[PULSE_W-1:1]};

        t1 = {r_rem, r_div[DIVD_W-1]};
        q1 = (t1 >= DIVISOR);
        r1 = q1 ? REM_W'(t1 - DIVISOR) : REM_W'(t1);
        t2 = {r1, r_div[DIVD_W-2]};
        q2 = (t2 >= DIVISOR);
        r2 = q2 ? REM_W'(t2 - DIVISOR) : REM_W'(t2);
    end

    always_comb begin
        n_cfg       = r_cfg;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_integ     = r_integ;
        n_prev      = r_prev;
        n_o_valid   = r_o_valid;
        n_meas      = r_meas;
        n_err       = r_err;
        n_deriv     = r_deriv;
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_pulse     = r_pulse;
        n_limited   = r_limited;
        n_macc      = r_macc;
        n_mlo       = r_mlo;
        n_div       = r_div;
        n_rem       = r_rem;
        n_o_pulse   = r_o_pulse;
        n_o_cmp     = r_o_cmp;
        n_o_limited = r_o_limited;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_SETPOINT:   n_cfg.setpoint     = i_cfg_wdata[SET_W-1:0];
                REG_GAIN_P:     n_cfg.gain_p       = $signed(i_cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_I:     n_cfg.gain_i       = $signed(i_cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_D:     n_cfg.gain_d       = $signed(i_cfg_wdata[GAIN_W-1:0]);
                REG_CENTER:     n_cfg.center_pulse = i_cfg_wdata[PULSE_W-1:0];
                REG_MIN_PULSE:  n_cfg.min_pulse    = i_cfg_wdata[PULSE_W-1:0];
                REG_MAX_PULSE:  n_cfg.max_pulse    = i_cfg_wdata[PULSE_W-1:0];
                REG_PWM_PERIOD: n_cfg.pwm_period   = i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_meas  = i_measured;
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                if (integ_raw > ERR_W'(INTEG_LIMIT)) begin
                    n_integ = INTEG_LIMIT;
                end else if (integ_raw < ERR_W'(INTEG_LIMIT_N)) begin
                    n_integ = INTEG_LIMIT_N;
                end else begin
                    n_integ = INTEG_W'(integ_raw);
                end
                n_err   = e_new;
                n_deriv = e_new - r_prev;
                n_prev  = e_new;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_acc = acc_sum[ACC_X_W-1:1];
                n_lo  = {acc_sum[0], r_lo[GAIN_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                if (pulse_raw < pulse_min) begin
                    n_pulse   = r_cfg.min_pulse;
                    n_limited = 1'b1;
                end else if (pulse_raw > pulse_max) begin
                    n_pulse   = r_cfg.max_pulse;
                    n_limited = 1'b1;
                end else begin
                    n_pulse   = pulse_raw[PULSE_W-1:0];
                    n_limited = 1'b0;
                end
                n_mlo   = n_pulse;
                n_macc  = '0;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_macc = msum[PERIOD_W:1];
                n_mlo  = {msum[0], r_mlo[PULSE_W-1:1]};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PULSE_W - 1)) begin
                    n_div   = DIVD_W'(product[PROD_W-1:DIV_SHIFT]);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_div = {r_div[DIVD_W-3:0], q1, q2};
                n_rem = r2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_pulse   = r_pulse;
                    n_o_limited = r_limited;
                    n_o_cmp     = (|r_div[DIVD_W-1:CMP_W]) ? '1 : r_div[CMP_W-1:0];
                    n_o_valid   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RESET;
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_integ   <= '0;
            r_prev    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cfg     <= n_cfg;
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_integ   <= n_integ;
            r_prev    <= n_prev;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas      <= n_meas;
        r_err       <= n_err;
        r_deriv     <= n_deriv;
        r_acc       <= n_acc;
        r_lo        <= n_lo;
        r_pulse     <= n_pulse;
        r_limited   <= n_limited;
        r_macc      <= n_macc;
        r_mlo       <= n_mlo;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_o_pulse   <= n_o_pulse;
        r_o_cmp     <= n_o_cmp;
        r_o_limited <= n_o_limited;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_pulse         = r_o_pulse;
    assign o_compare_value = r_o_cmp;
    assign o_limited       = r_o_limited;

endmodule

`default_nettype wire

// ===== rtl/core/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks for the servo pulse PID controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_checker
    import psc_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire [PULSE_W-1:0]    o_pulse,
    input wire [CMP_W-1:0]      o_compare_value,
    input wire                  o_limited
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_pulse) && $stable(o_compare_value) && $stable(o_limited))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while busy");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared right after input beat");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind pid_servo_pulse_controller psc_checker u_psc_checker (.*);

`default_nettype wire

// ===== test/pid_servo_pulse_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_servo_pulse_controller_tb
// Self-checking bench for the servo pulse PID controller. A behavioral
// predictor tracks the integral and the previous error and computes pulse,
// compare value and limited flag for every accepted sample. Directed cases
// cover reset values, integral clamping, clamp order with crossed bounds,
// bounds above 1000 with compare saturation and a zero period. Random phases
// then load new register settings and stream samples with random gaps on
// both sides, a long output stall and sender pauses.
// ----------------------------------------------------------------------------
module pid_servo_pulse_controller_tb;
    import psc_pkg::*;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse;
        logic [CMP_W-1:0]   compare_value;
        logic               limited;
    } servo_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MEAS_W-1:0]     measured = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PULSE_W-1:0]    pulse;
    logic [CMP_W-1:0]      compare_value;
    logic                  limited;

    // predictor state
    t_cfg        pid_cfg = CFG_RESET;
    int          integ_sum = 0;
    int          last_error = 0;
    servo_beat_t servo_expected[$];

    int fails = 0;
    int sent = 0;
    int checked = 0;
    int cfg_loads = 0;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int hold_len = 0;
    int hold_tok = 0;
    int hold_seen = 0;
    int rx_hold = 0;
    int rx_wait = 0;

    pid_servo_pulse_controller u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_measured      (measured),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_pulse         (pulse),
        .o_compare_value (compare_value),
        .o_limited       (limited)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic servo_beat_t predict_servo(input logic [MEAS_W-1:0] m);
        servo_beat_t r;
        longint err, integ, deriv, acc, pls, cmp;
        err   = longint'(pid_cfg.setpoint) - longint'(m);
        integ = longint'(integ_sum) + err;
        if (integ > longint'(INTEG_LIMIT))
            integ = longint'(INTEG_LIMIT);
        else if (integ < longint'(INTEG_LIMIT_N))
            integ = longint'(INTEG_LIMIT_N);
        deriv      = err - longint'(last_error);
        integ_sum  = int'(integ);
        last_error = int'(err);
        acc = longint'($signed(pid_cfg.gain_p)) * err
            + longint'($signed(pid_cfg.gain_i)) * integ
            + longint'($signed(pid_cfg.gain_d)) * deriv;
        pls = longint'(pid_cfg.center_pulse) - (acc >>> GAIN_FRAC_BITS);
        r.limited = 1'b0;
        // min bound wins when the bounds cross
        if (pls < longint'(pid_cfg.min_pulse)) begin
            pls = longint'(pid_cfg.min_pulse);
            r.limited = 1'b1;
        end else if (pls > longint'(pid_cfg.max_pulse)) begin
            pls = longint'(pid_cfg.max_pulse);
            r.limited = 1'b1;
        end
        cmp = (longint'(pid_cfg.pwm_period) * pls) / 1000;
        if (cmp > 65535)
            cmp = 65535;
        r.pulse         = pls[PULSE_W-1:0];
        r.compare_value = cmp[CMP_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic t_cfg make_cfg(input int sp, input int kp, input int ki,
                                      input int kd, input int ctr, input int mn,
                                      input int mx, input int per);
        t_cfg c;
        c.setpoint     = 16'(sp);
        c.gain_p       = 16'(kp);
        c.gain_i       = 16'(ki);
        c.gain_d       = 16'(kd);
        c.center_pulse = 10'(ctr);
        c.min_pulse    = 10'(mn);
        c.max_pulse    = 10'(mx);
        c.pwm_period   = 16'(per);
        return c;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2, 3:    return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.setpoint = 16'($urandom);
        c.gain_p   = rand_gain();
        c.gain_i   = rand_gain();
        c.gain_d   = rand_gain();
        if ($urandom_range(0, 3) == 0) begin
            c.center_pulse = 10'($urandom);
            c.min_pulse    = 10'($urandom);
            c.max_pulse    = 10'($urandom);
        end else begin
            c.center_pulse = 10'($urandom_range(300, 700));
            c.min_pulse    = 10'($urandom_range(0, 400));
            c.max_pulse    = 10'($urandom_range(600, 1000));
        end
        case ($urandom_range(0, 5))
            0:       c.pwm_period = '0;
            1:       c.pwm_period = 16'hFFFF;
            default: c.pwm_period = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [MEAS_W-1:0] rand_measured();
        int v;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: begin
                v = int'(pid_cfg.setpoint) + int'($urandom_range(0, 400)) - 200;
                if (v < 0)
                    v = 0;
                else if (v > 65535)
                    v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // output side: checks each beat, then draws its stall for the next one
    always @(posedge clk) begin : rx_side
        servo_beat_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (servo_expected.size() == 0) begin
                    $error("pulse: expected none, actual %0d", pulse);
                    fails++;
                end else begin
                    want = servo_expected.pop_front();
                    check_field("pulse", 32'(want.pulse), 32'(pulse));
                    check_field("compare_value", 32'(want.compare_value),
                                32'(compare_value));
                    check_field("limited", 32'(want.limited), 32'(limited));
                    checked++;
                end
                rx_wait = rx_idle_on ? pick_gap() : 0;
            end
            if (hold_tok != hold_seen) begin
                hold_seen = hold_tok;
                rx_hold   = hold_len;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [MEAS_W-1:0] m);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        measured <= m;
        do @(posedge clk); while (!in_ready);
        servo_expected.push_back(predict_servo(m));
        sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (servo_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // upper bits of the 10-bit registers carry junk, the block drops them
    task automatic load_config(input t_cfg c);
        write_reg(REG_SETPOINT, c.setpoint);
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_GAIN_D, c.gain_d);
        write_reg(REG_CENTER, {6'($urandom), c.center_pulse});
        write_reg(REG_MIN_PULSE, {6'($urandom), c.min_pulse});
        write_reg(REG_MAX_PULSE, {6'($urandom), c.max_pulse});
        write_reg(REG_PWM_PERIOD, c.pwm_period);
        cfg_wr_en <= 1'b0;
        pid_cfg = c;
        cfg_loads++;
        @(posedge clk);
    endtask

    task automatic set_idle(input bit tx, input bit rx);
        tx_idle_on = tx;
        rx_idle_on <= rx;
    endtask

    task automatic test_reset_defaults();
        set_idle(1'b1, 1'b1);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd75);
        send_sample(16'd76);
        send_sample(16'd74);
        wait_idle();
    endtask

    task automatic test_integral_clamp();
        load_config(make_cfg(32768, 0, 256, 0, 500, 0, 1000, 65535));
        repeat (3) send_sample(16'd0);
        repeat (3) send_sample(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_crossed_bounds();
        load_config(make_cfg(0, 256, 0, 0, 500, 800, 200, 20000));
        send_sample(16'd0);
        send_sample(16'd500);
        send_sample(16'd300);
        wait_idle();
    endtask

    task automatic test_wide_bounds();
        load_config(make_cfg(65535, -32768, -32768, 32767, 1023, 0, 1023, 65535));
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        wait_idle();
        // compare saturation
        load_config(make_cfg(0, 0, 0, 0, 1023, 1023, 1023, 65535));
        send_sample(16'd0);
        wait_idle();
        load_config(make_cfg(100, 32767, 32767, -32768, 0, 0, 0, 0));
        send_sample(16'd0);
        send_sample(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_random_configs(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            load_config(rand_cfg());
            case ($urandom_range(0, 3))
                0:       set_idle(1'b0, 1'b0);
                1:       set_idle(1'b1, 1'b0);
                2:       set_idle(1'b0, 1'b1);
                default: set_idle(1'b1, 1'b1);
            endcase
            repeat (per_phase) send_sample(rand_measured());
            wait_idle();
        end
    endtask

    task automatic test_output_stall();
        load_config(rand_cfg());
        set_idle(1'b0, 1'b1);
        hold_len <= 400;
        hold_tok <= hold_tok + 1;
        repeat (10) send_sample(rand_measured());
        wait_idle();
    endtask

    task automatic test_sender_pause();
        set_idle(1'b1, 1'b1);
        repeat (4) begin
            repeat (5) send_sample(rand_measured());
            wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_integral_clamp();
        test_crossed_bounds();
        test_wide_bounds();
        test_random_configs(6, 100);
        test_output_stall();
        test_sender_pause();
        wait_idle();
        repeat (60) @(posedge clk);
        if (servo_expected.size() != 0) begin
            $error("results missing: %0d", servo_expected.size());
            fails++;
        end
        $display("Checked %0d results for %0d samples across %0d register loads,",
                 checked, sent, cfg_loads);
        $display("incl. clamps, crossed and wide bounds, output stall and sender pauses.");
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/psc_pkg.sv
rtl/core/pid_servo_pulse_controller.sv
rtl/core/psc_checker.sv
test/pid_servo_pulse_controller_tb.sv
